>>> rtl/ipec_pkg.sv
package ipec_pkg;

	// Table depths
	localparam int V4_ENTRIES = 16;
	localparam int V6_ENTRIES = 8;

	localparam int V4_AW = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
	localparam int V6_AW = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
	localparam int MAX_ENTRIES = (V4_ENTRIES > V6_ENTRIES) ? V4_ENTRIES : V6_ENTRIES;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	// Item kinds
	localparam logic [1:0] KIND_WR_V4 = 2'd0;
	localparam logic [1:0] KIND_WR_V6 = 2'd1;
	localparam logic [1:0] KIND_Q_V4  = 2'd2;
	localparam logic [1:0] KIND_Q_V6  = 2'd3;

	// Verdict reasons
	localparam logic [2:0] RSN_EXTERNAL = 3'd0;
	localparam logic [2:0] RSN_RESERVED = 3'd1;
	localparam logic [2:0] RSN_LOCAL    = 3'd2;
	localparam logic [2:0] RSN_BRIDGE   = 3'd3;
	localparam logic [2:0] RSN_V6_IFACE = 3'd4;
	localparam logic [2:0] RSN_V6_RANGE = 3'd5;

	// Special-purpose IPv4 ranges
	localparam int RSV_COUNT = 17;
	localparam logic [31:0] RSV_NET [RSV_COUNT] = '{
		32'h00000000, 32'h0a000000, 32'h64400000, 32'h7f000000, 32'ha9fe0000,
		32'hac100000, 32'hc0000000, 32'hc0000200, 32'hc0586300, 32'hc0a80000,
		32'hc6120000, 32'hc6336400, 32'hcb007100, 32'he0000000, 32'he9fc0000,
		32'hf0000000, 32'hffffffff
	};
	localparam logic [31:0] RSV_MASK [RSV_COUNT] = '{
		32'hff000000, 32'hff000000, 32'hffc00000, 32'hff000000, 32'hffff0000,
		32'hfff00000, 32'hffffff00, 32'hffffff00, 32'hffffff00, 32'hffff0000,
		32'hfffe0000, 32'hffffff00, 32'hffffff00, 32'hf0000000, 32'hffff0000,
		32'hf0000000, 32'hffffffff
	};

	// IPv4 table entry
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] mask;
		logic        bridge;
	} v4_entry_t;

	// IPv6 table entry
	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [63:0] mask_high;
		logic [63:0] mask_low;
	} v6_entry_t;

	// Read word from a table: stored entry plus its in-use bit
	typedef struct packed {
		v4_entry_t entry;
		logic      used;
	} v4_word_t;

	typedef struct packed {
		v6_entry_t entry;
		logic      used;
	} v6_word_t;

	// True when the address falls in any special-purpose range
	function automatic logic rsv_hit(input logic [31:0] a);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < RSV_COUNT; i++) begin
			if ((a & RSV_MASK[i]) == RSV_NET[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

>>> rtl/ip_address_external_classifier_core.sv
// Channel  Dir  Handshake             Word
// in       in   in_valid / in_ready   kind, entry_index, entry_valid, is_bridge,
//                                     addr_high, addr_low, mask_high, mask_low
// out      out  out_valid / out_ready is_external, reason
//
// A write gives no result; the next word is taken at once.
// A query walks its table one entry at a time (v4 table: 16 entries,
// v6 table: 8), set by the single read port of each table memory; a query
// that hits a reserved v4 range skips the walk. No word is taken meanwhile.
// Reset clears the in-use bits of both tables and all control state.
// A result waits in the output register; a query that finishes while it is
// still held waits until out_ready frees it.
module ip_address_external_classifier_core
	import ipec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  entry_index,
	input  logic        entry_valid,
	input  logic        is_bridge,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic [63:0] mask_high,
	input  logic [63:0] mask_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_external,
	output logic [2:0]  reason
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RSV  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic             accept;
	logic             embedded;
	logic             v4_mode_q;
	logic [31:0]      a4_q;
	logic [63:0]      hi_q;
	logic [63:0]      lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] limit;
	logic             issue;
	logic             rvld_s1;
	logic             rlast_s1;
	logic             hit2_q;
	logic             hit3_q;
	logic             hit4_q;
	logic             m2;
	logic             m3;
	logic             m4;
	logic             v6_range;
	logic [2:0]       res_q;
	logic [2:0]       final_res;
	logic             out_valid_q;
	logic             is_external_q;
	logic [2:0]       reason_q;
	logic             load_out;

	logic             v4_wr_en;
	logic             v6_wr_en;
	v4_entry_t        v4_wr_entry;
	v6_entry_t        v6_wr_entry;
	v4_word_t         v4_rd;
	v6_word_t         v6_rd;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Detect an IPv4 address embedded in an IPv6 query
	assign embedded = ((addr_high == 64'h0) && (addr_low[63:32] == 32'hffff0000)) ||
		((addr_high == 64'h0064ff9b00000000) && (addr_low[63:32] == 32'h0)) ||
		((addr_high == 64'h0) && (addr_low[63:32] == 32'h0000ffff));

	// Table writes straight from the accepted word
	assign v4_wr_en = accept && (kind == KIND_WR_V4) &&
		(32'(entry_index) < 32'(V4_ENTRIES));
	assign v6_wr_en = accept && (kind == KIND_WR_V6) &&
		(32'(entry_index) < 32'(V6_ENTRIES));

	assign v4_wr_entry.addr   = addr_low[31:0];
	assign v4_wr_entry.mask   = mask_low[31:0];
	assign v4_wr_entry.bridge = is_bridge;

	assign v6_wr_entry.addr_high = addr_high;
	assign v6_wr_entry.addr_low  = addr_low;
	assign v6_wr_entry.mask_high = mask_high;
	assign v6_wr_entry.mask_low  = mask_low;

	// Walk one entry per cycle
	assign limit = v4_mode_q ? CNT_W'(V4_ENTRIES) : CNT_W'(V6_ENTRIES);
	assign issue = (state_q == S_SCAN) && (cnt_q != limit);

	ipec_v4_tbl u_v4_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (v4_wr_en),
		.wr_idx   (V4_AW'(entry_index)),
		.wr_entry (v4_wr_entry),
		.wr_used  (entry_valid),
		.rd_en    (issue && v4_mode_q),
		.rd_idx   (cnt_q[V4_AW-1:0]),
		.rd_word  (v4_rd)
	);

	ipec_v6_tbl u_v6_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (v6_wr_en),
		.wr_idx   (V6_AW'(entry_index)),
		.wr_entry (v6_wr_entry),
		.wr_used  (entry_valid),
		.rd_en    (issue && !v4_mode_q),
		.rd_idx   (cnt_q[V6_AW-1:0]),
		.rd_word  (v6_rd)
	);

	// Match the returned entry against the query
	assign m2 = v4_rd.used && !v4_rd.entry.bridge && (v4_rd.entry.addr == a4_q);
	assign m3 = v4_rd.used && v4_rd.entry.bridge &&
		((a4_q & v4_rd.entry.mask) == (v4_rd.entry.addr & v4_rd.entry.mask));
	assign m4 = v6_rd.used &&
		((hi_q & v6_rd.entry.mask_high) ==
		 (v6_rd.entry.addr_high & v6_rd.entry.mask_high)) &&
		((lo_q & v6_rd.entry.mask_low) ==
		 (v6_rd.entry.addr_low & v6_rd.entry.mask_low));

	assign v6_range = (hi_q[63:57] == 7'h7e) || (hi_q[63:54] == 10'h3fb) ||
		(hi_q[63:54] == 10'h3fa) || ((hi_q == 64'h0) && (lo_q == 64'h1));

	// Settle the verdict after the last entry
	always_comb begin
		final_res = RSN_EXTERNAL;
		if (v4_mode_q) begin
			priority if (hit2_q || m2) begin
				final_res = RSN_LOCAL;
			end else if (hit3_q || m3) begin
				final_res = RSN_BRIDGE;
			end
		end else begin
			priority if (hit4_q || m4) begin
				final_res = RSN_V6_IFACE;
			end else if (v6_range) begin
				final_res = RSN_V6_RANGE;
			end
		end
	end

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Capture the query word
	always_ff @(posedge clk) begin
		if (accept) begin
			a4_q <= addr_low[31:0];
			hi_q <= addr_high;
			lo_q <= addr_low;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			v4_mode_q <= 1'b0;
			cnt_q     <= '0;
			rvld_s1   <= 1'b0;
			rlast_s1  <= 1'b0;
			hit2_q    <= 1'b0;
			hit3_q    <= 1'b0;
			hit4_q    <= 1'b0;
			res_q     <= RSN_EXTERNAL;
		end else begin
			rvld_s1  <= issue;
			rlast_s1 <= issue && (cnt_q == limit - CNT_W'(1));
			unique case (state_q)
				S_IDLE: begin
					if (accept && ((kind == KIND_Q_V4) || (kind == KIND_Q_V6))) begin
						v4_mode_q <= (kind == KIND_Q_V4) || embedded;
						state_q   <= S_RSV;
					end
				end
				S_RSV: begin
					cnt_q  <= '0;
					hit2_q <= 1'b0;
					hit3_q <= 1'b0;
					hit4_q <= 1'b0;
					if (v4_mode_q && rsv_hit(a4_q)) begin
						res_q   <= RSN_RESERVED;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (rvld_s1) begin
						hit2_q <= hit2_q || m2;
						hit3_q <= hit3_q || m3;
						hit4_q <= hit4_q || m4;
					end
					if (rlast_s1) begin
						res_q   <= final_res;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			is_external_q <= (res_q == RSN_EXTERNAL);
			reason_q      <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_external = is_external_q;
	assign reason      = reason_q;

endmodule

>>> rtl/ipec_v4_tbl.sv
module ipec_v4_tbl
	import ipec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [V4_AW-1:0] wr_idx,
	input  v4_entry_t        wr_entry,
	input  logic             wr_used,
	input  logic             rd_en,
	input  logic [V4_AW-1:0] rd_idx,
	output v4_word_t         rd_word
);

	v4_entry_t              mem [V4_ENTRIES];
	logic [V4_ENTRIES-1:0]  used_q;
	v4_entry_t              rd_entry_q;
	logic                   rd_used_q;

	// Write entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= mem[rd_idx];
		end
	end

	// Hold in-use bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (wr_en) begin
				used_q[wr_idx] <= wr_used;
			end
			if (rd_en) begin
				rd_used_q <= used_q[rd_idx];
			end
		end
	end

	assign rd_word.entry = rd_entry_q;
	assign rd_word.used  = rd_used_q;

endmodule

>>> rtl/ipec_v6_tbl.sv
module ipec_v6_tbl
	import ipec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [V6_AW-1:0] wr_idx,
	input  v6_entry_t        wr_entry,
	input  logic             wr_used,
	input  logic             rd_en,
	input  logic [V6_AW-1:0] rd_idx,
	output v6_word_t         rd_word
);

	v6_entry_t              mem [V6_ENTRIES];
	logic [V6_ENTRIES-1:0]  used_q;
	v6_entry_t              rd_entry_q;
	logic                   rd_used_q;

	// Write entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= mem[rd_idx];
		end
	end

	// Hold in-use bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (wr_en) begin
				used_q[wr_idx] <= wr_used;
			end
			if (rd_en) begin
				rd_used_q <= used_q[rd_idx];
			end
		end
	end

	assign rd_word.entry = rd_entry_q;
	assign rd_word.used  = rd_used_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import ipec_pkg::*;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int SPECIAL_COUNT   = 17;

	// Special-purpose IPv4 ranges, kept apart from the package copy
	localparam logic [31:0] SPECIAL_NET [SPECIAL_COUNT] = '{
		32'h00000000, 32'h0a000000, 32'h64400000, 32'h7f000000, 32'ha9fe0000,
		32'hac100000, 32'hc0000000, 32'hc0000200, 32'hc0586300, 32'hc0a80000,
		32'hc6120000, 32'hc6336400, 32'hcb007100, 32'he0000000, 32'he9fc0000,
		32'hf0000000, 32'hffffffff
	};
	localparam logic [31:0] SPECIAL_MASK [SPECIAL_COUNT] = '{
		32'hff000000, 32'hff000000, 32'hffc00000, 32'hff000000, 32'hffff0000,
		32'hfff00000, 32'hffffff00, 32'hffffff00, 32'hffffff00, 32'hffff0000,
		32'hfffe0000, 32'hffffff00, 32'hffffff00, 32'hf0000000, 32'hffff0000,
		32'hf0000000, 32'hffffffff
	};

	typedef struct {
		logic       ext;
		logic [2:0] rsn;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = KIND_WR_V4;
	logic [3:0]  entry_index = '0;
	logic        entry_valid = 1'b0;
	logic        is_bridge = 1'b0;
	logic [63:0] addr_high = '0;
	logic [63:0] addr_low = '0;
	logic [63:0] mask_high = '0;
	logic [63:0] mask_low = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_external;
	logic [2:0]  reason;

	// Shadow interface tables
	v4_entry_t v4_tbl [V4_ENTRIES];
	logic      v4_used [V4_ENTRIES] = '{default: 1'b0};
	v6_entry_t v6_tbl [V6_ENTRIES];
	logic      v6_used [V6_ENTRIES] = '{default: 1'b0};

	verdict_t pending_verdicts [$];
	int       fail_count = 0;
	int       idle_cycles = 0;
	bit       gaps_on = 1'b1;
	bit       hold_off_req = 1'b0;

	ip_address_external_classifier_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.entry_index (entry_index),
		.entry_valid (entry_valid),
		.is_bridge   (is_bridge),
		.addr_high   (addr_high),
		.addr_low    (addr_low),
		.mask_high   (mask_high),
		.mask_low    (mask_low),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_external (is_external),
		.reason      (reason)
	);

	initial begin
		forever begin
			#4 clk = ~clk;
		end
	end

	// Classify an IPv4 address against the special ranges and the shadow table
	function automatic logic [2:0] v4_reason(input logic [31:0] a);
		for (int i = 0; i < SPECIAL_COUNT; i++) begin
			if ((a & SPECIAL_MASK[i]) == SPECIAL_NET[i]) begin
				return RSN_RESERVED;
			end
		end
		for (int i = 0; i < V4_ENTRIES; i++) begin
			if (v4_used[i] && !v4_tbl[i].bridge && v4_tbl[i].addr == a) begin
				return RSN_LOCAL;
			end
		end
		for (int i = 0; i < V4_ENTRIES; i++) begin
			if (v4_used[i] && v4_tbl[i].bridge &&
			    (a & v4_tbl[i].mask) == (v4_tbl[i].addr & v4_tbl[i].mask)) begin
				return RSN_BRIDGE;
			end
		end
		return RSN_EXTERNAL;
	endfunction

	// Unwrap an embedded IPv4 address, else check subnets and internal ranges
	function automatic logic [2:0] v6_reason(input logic [63:0] hi, input logic [63:0] lo);
		logic [31:0] mid;
		mid = lo[63:32];
		if ((hi == '0 && mid == 32'hffff0000) ||
		    (hi == 64'h0064ff9b00000000 && mid == '0) ||
		    (hi == '0 && mid == 32'h0000ffff)) begin
			return v4_reason(lo[31:0]);
		end
		for (int i = 0; i < V6_ENTRIES; i++) begin
			if (v6_used[i] &&
			    (hi & v6_tbl[i].mask_high) == (v6_tbl[i].addr_high & v6_tbl[i].mask_high) &&
			    (lo & v6_tbl[i].mask_low) == (v6_tbl[i].addr_low & v6_tbl[i].mask_low)) begin
				return RSN_V6_IFACE;
			end
		end
		if (hi[63:57] == 7'h7e || hi[63:54] == 10'h3fb || hi[63:54] == 10'h3fa ||
		    (hi == '0 && lo == 64'd1)) begin
			return RSN_V6_RANGE;
		end
		return RSN_EXTERNAL;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] v4_prefix(input int len);
		logic [31:0] m;
		m = '1;
		if (len == 0) begin
			return '0;
		end
		return m << (32 - len);
	endfunction

	function automatic logic [127:0] v6_prefix(input int len);
		logic [127:0] m;
		m = '1;
		if (len == 0) begin
			return '0;
		end
		return m << (128 - len);
	endfunction

	// Aim an IPv4 address at special ranges, table addresses or table subnets
	function automatic logic [31:0] pick_v4();
		int i;
		logic [31:0] a;
		a = $urandom;
		i = $urandom_range(0, V4_ENTRIES - 1);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				i = $urandom_range(0, SPECIAL_COUNT - 1);
				a = SPECIAL_NET[i] | (a & ~SPECIAL_MASK[i]);
			end
			3, 4: a = v4_tbl[i].addr;
			5, 6: a = (v4_tbl[i].addr & v4_tbl[i].mask) | (a & ~v4_tbl[i].mask);
			default: ;
		endcase
		return a;
	endfunction

	// Aim an IPv6 address at embedded forms, table subnets and internal ranges
	function automatic logic [127:0] pick_v6();
		int i;
		logic [127:0] a;
		logic [127:0] m;
		a = {rand64(), rand64()};
		i = $urandom_range(0, V6_ENTRIES - 1);
		case ($urandom_range(0, 9))
			0: a = {64'h0, 32'hffff0000, pick_v4()};
			1: a = {64'h0064ff9b00000000, 32'h0, pick_v4()};
			2: a = {64'h0, 32'h0000ffff, pick_v4()};
			3: begin
				// near miss: one stray bit in the prefix
				case ($urandom_range(0, 2))
					0: a = {64'h0, 32'hffff0000, pick_v4()};
					1: a = {64'h0064ff9b00000000, 32'h0, pick_v4()};
					default: a = {64'h0, 32'h0000ffff, pick_v4()};
				endcase
				a[$urandom_range(32, 127)] ^= 1'b1;
			end
			4, 5, 6: begin
				m = {v6_tbl[i].mask_high, v6_tbl[i].mask_low};
				a = ({v6_tbl[i].addr_high, v6_tbl[i].addr_low} & m) | (a & ~m);
			end
			7: begin
				case ($urandom_range(0, 3))
					0: a[127:121] = 7'h7e;
					1: a[127:118] = 10'h3fb;
					2: a[127:118] = 10'h3fa;
					default: a = 128'd1;
				endcase
			end
			default: ;
		endcase
		return a;
	endfunction

	// Offer one word, wait for it to be taken, then fold it into the shadow state
	task automatic push_word(input logic [1:0] k, input logic [3:0] idx, input logic vld,
	                         input logic brg, input logic [63:0] ah, input logic [63:0] al,
	                         input logic [63:0] mh, input logic [63:0] ml);
		logic [2:0] r;
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		entry_index <= idx;
		entry_valid <= vld;
		is_bridge   <= brg;
		addr_high   <= ah;
		addr_low    <= al;
		mask_high   <= mh;
		mask_low    <= ml;
		do @(posedge clk); while (!in_ready);
		case (k)
			KIND_WR_V4: begin
				if (idx < V4_ENTRIES) begin
					v4_tbl[idx] = '{addr: al[31:0], mask: ml[31:0], bridge: brg};
					v4_used[idx] = vld;
				end
			end
			KIND_WR_V6: begin
				if (idx < V6_ENTRIES) begin
					v6_tbl[idx] = '{addr_high: ah, addr_low: al, mask_high: mh, mask_low: ml};
					v6_used[idx] = vld;
				end
			end
			KIND_Q_V4: begin
				r = v4_reason(al[31:0]);
				pending_verdicts.push_back('{ext: (r == RSN_EXTERNAL), rsn: r});
			end
			default: begin
				r = v6_reason(ah, al);
				pending_verdicts.push_back('{ext: (r == RSN_EXTERNAL), rsn: r});
			end
		endcase
	endtask

	task automatic write_v4(input int idx, input logic vld, input logic brg,
	                        input logic [31:0] a, input logic [31:0] m);
		push_word(KIND_WR_V4, 4'(idx), vld, brg, rand64(), {$urandom, a}, rand64(),
		          {$urandom, m});
	endtask

	task automatic write_v6(input int idx, input logic vld, input logic [127:0] a,
	                        input logic [127:0] m);
		push_word(KIND_WR_V6, 4'(idx), vld, 1'($urandom_range(0, 1)), a[127:64], a[63:0],
		          m[127:64], m[63:0]);
	endtask

	task automatic query_v4(input logic [31:0] a);
		push_word(KIND_Q_V4, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
		          1'($urandom_range(0, 1)), rand64(), {$urandom, a}, rand64(), rand64());
	endtask

	task automatic query_v6(input logic [127:0] a);
		push_word(KIND_Q_V6, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
		          1'($urandom_range(0, 1)), a[127:64], a[63:0], rand64(), rand64());
	endtask

	// Write every slot as unused so that no query walks over unwritten entries
	task automatic clear_tables();
		for (int i = 0; i < 16; i++) begin
			write_v4(i, 1'b0, 1'($urandom_range(0, 1)), $urandom, $urandom);
		end
		for (int i = 0; i < 16; i++) begin
			write_v6(i, 1'b0, {rand64(), rand64()}, {rand64(), rand64()});
		end
	endtask

	// Edges of the special ranges and the all-zero and all-one addresses
	task automatic test_reserved_ranges();
		query_v4(32'h00000000);
		query_v4(32'hffffffff);
		query_v4(32'h08080808);
		query_v4(32'h647fffff);
		query_v4(32'h64800000);
		query_v4(32'hac1fffff);
		query_v4(32'hac200000);
		query_v4(32'hf0000000);
	endtask

	// Local addresses, bridge subnets, removal and slots beyond the v6 table
	task automatic test_interface_tables();
		write_v4(3, 1'b1, 1'b0, 32'h08080808, 32'hffffff00);
		query_v4(32'h08080808);
		write_v4(5, 1'b1, 1'b1, 32'h09090000, 32'hffff0000);
		query_v4(32'h09091234);
		write_v4(3, 1'b0, 1'b0, 32'h08080808, 32'hffffffff);
		query_v4(32'h08080808);
		write_v6(7, 1'b1, {64'h20010db800000000, 64'h0}, v6_prefix(32));
		query_v6({64'h20010db800010000, 64'h5});
		write_v6(12, 1'b1, {64'h3ffe000000000000, 64'h0}, v6_prefix(16));
		query_v6({64'h3ffe000000000001, 64'h7});
	endtask

	// Embedded IPv4 forms, a near miss on byte nine, and internal v6 ranges
	task automatic test_v6_forms();
		query_v6({64'h0, 32'hffff0000, 32'h0a000001});
		query_v6({64'h0064ff9b00000000, 32'h0, 32'h09090505});
		query_v6({64'h0, 32'h0000ffff, 32'h08080808});
		query_v6({64'h0, 32'h0001ffff, 32'h0a000001});
		query_v6({64'h0, 64'h1});
		query_v6({64'hfc00000000000000, 64'h1});
		query_v6({64'hfe80000000000000, 64'h1});
		query_v6({64'hfeffffffffffffff, 64'hffffffffffffffff});
	endtask

	// Mostly queries aimed at the tables, with writes that reshape them
	task automatic random_word();
		int sel;
		logic [31:0] a4;
		logic [31:0] m4;
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			if (sel < 12) begin
				a4 = ($urandom_range(0, 3) == 0) ? pick_v4() : $urandom;
				m4 = ($urandom_range(0, 7) == 0) ? $urandom :
				     v4_prefix(($urandom_range(0, 15) == 0) ? $urandom_range(0, 32) :
				               $urandom_range(8, 32));
				write_v4($urandom_range(0, 15), $urandom_range(0, 3) != 0,
				         1'($urandom_range(0, 1)), a4, m4);
			end else begin
				write_v6($urandom_range(0, 15), $urandom_range(0, 3) != 0,
				         ($urandom_range(0, 3) == 0) ? pick_v6() : {rand64(), rand64()},
				         ($urandom_range(0, 7) == 0) ? {rand64(), rand64()} :
				         v6_prefix(($urandom_range(0, 15) == 0) ? $urandom_range(0, 128) :
				                   $urandom_range(16, 128)));
			end
		end else if (sel < 60) begin
			query_v4(pick_v4());
		end else begin
			query_v6(pick_v6());
		end
	endtask

	task automatic test_random_traffic(input int n);
		repeat (n) random_word();
	endtask

	// Hold the result side off for a long stretch while queries keep coming
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		repeat (40) begin
			if ($urandom_range(0, 1) == 0) begin
				query_v4(pick_v4());
			end else begin
				query_v6(pick_v6());
			end
		end
	endtask

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each result word with the oldest pending verdict
	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result word with no query pending: is_external=%0b reason=%0d",
				       is_external, reason);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (is_external !== want.ext) begin
					$error("is_external: expected %0b, got %0b", want.ext, is_external);
					fail_count++;
				end
				if (reason !== want.rsn) begin
					$error("reason: expected %0d, got %0d", want.rsn, reason);
					fail_count++;
				end
			end
		end
	end

	// Drop the run when neither side moves a word for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL ip_address_external_classifier_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : test_sequence
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		clear_tables();
		test_reserved_ranges();
		test_interface_tables();
		test_v6_forms();
		test_random_traffic(1200);
		test_backpressure();
		// closing stretch runs at full rate on both sides
		gaps_on = 1'b0;
		test_random_traffic(300);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS ip_address_external_classifier_core");
		end else begin
			$display("FAIL ip_address_external_classifier_core");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/ipec_pkg.sv
rtl/ipec_v4_tbl.sv
rtl/ipec_v6_tbl.sv
rtl/ip_address_external_classifier_core.sv
test/tb.sv
